[src/pwmcap_pkg.sv]
`timescale 1ns / 1ps

package pwmcap_pkg;

	// phase counts as reported
	localparam int TICK_W = 16;
	// widest dividend or divisor: 17 bit total shifted by up to 10
	localparam int DIV_W = 27;
	localparam int STEP_W = $clog2(DIV_W);
	localparam int DUTY_W = 7;

	localparam logic [DIV_W-1:0] HZ_PER_MHZ = DIV_W'(1000000);
	localparam logic [DIV_W-1:0] PCT_SCALE = DIV_W'(100);
	localparam logic [TICK_W-1:0] SAT_MAX = '1;

	// input kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	// register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_PRESCALE = 2'd0;
	localparam logic [1:0] REG_CLOCK = 2'd1;
	localparam logic [1:0] REG_ENABLE = 2'd2;

	// prescaler select codes
	localparam logic [2:0] PRE_1 = 3'd1;
	localparam logic [2:0] PRE_8 = 3'd2;
	localparam logic [2:0] PRE_64 = 3'd3;
	localparam logic [2:0] PRE_256 = 3'd4;
	localparam logic [2:0] PRE_1024 = 3'd5;

	typedef enum logic [2:0] {
		DIV_PERIOD,
		DIV_ON_US,
		DIV_OFF_US,
		DIV_DUTY,
		DIV_FREQ
	} div_op_t;

	typedef struct packed {
		logic    tick;
		logic    capture;
		logic    div_load;
		logic    div_step;
		logic    div_store;
		logic    out_load;
		div_op_t div_op;
	} cmd_t;

	typedef struct packed {
		logic edge_match;
		logic out_free;
	} sts_t;

	// output tdata layout, lowest field last
	typedef struct packed {
		logic              pad;
		logic [TICK_W-1:0] off_time_us;
		logic [TICK_W-1:0] on_time_us;
		logic [TICK_W-1:0] frequency_hz;
		logic [DUTY_W-1:0] duty_percent;
		logic [TICK_W-1:0] period_us;
		logic [TICK_W-1:0] off_ticks;
		logic [TICK_W-1:0] on_ticks;
	} result_t;

	// ticks times prescale factor, zero for an unused select code
	function automatic logic [DIV_W-1:0] prescale_apply(input logic [TICK_W:0] x,
			input logic [2:0] sel);
		logic [DIV_W-1:0] v;
		v = DIV_W'(x);
		case (sel)
			PRE_1:    prescale_apply = v;
			PRE_8:    prescale_apply = v << 3;
			PRE_64:   prescale_apply = v << 6;
			PRE_256:  prescale_apply = v << 8;
			PRE_1024: prescale_apply = v << 10;
			default:  prescale_apply = '0;
		endcase
	endfunction

endpackage

[src/pwm_input_capture_measure.sv]
`timescale 1ns / 1ps

// channel   dir  transaction                  payload
// s_axis    in   one timer tick or pin edge   tuser operation, tdata[0] edge_rising
// m_axis    out  one measurement per capture  tuser captured_high, tdata 104 bits
// apb       in   register write / read        prescale 0x0, clock_mhz 0x4, enable 0x8
//
// a tick is taken and counted in the same cycle, so ticks may arrive every clock while s_tready is high
// a capturing edge holds s_tready low until the result is handed off: one shared 27-step
// restoring divider runs five divisions, each a load, its steps and a store, then the hand-off
// the hand-off waits while an earlier result still sits unread in the output register
// arst_n clears the counter, phase counts and polarity; config registers take defaults

module pwm_input_capture_measure #(
	parameter int COUNTER_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,

	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [0] edge_rising, [7:1] zero
	input  logic          s_tuser,   // [0] operation

	output logic          m_tvalid,
	input  logic          m_tready,
	// [15:0] on_ticks, [31:16] off_ticks, [47:32] period_us, [54:48] duty_percent,
	// [70:55] frequency_hz, [86:71] on_time_us, [102:87] off_time_us, [103] zero
	output logic [103:0]  m_tdata,
	output logic          m_tuser,   // [0] captured_high

	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic [2:0] prescale_q;
	logic [5:0] clock_mhz_q;
	logic       enable_q;
	logic       cfg_write;

	pwmcap_pkg::cmd_t    cmd;
	pwmcap_pkg::sts_t    sts;
	pwmcap_pkg::result_t result;

	// register file, written in the apb access phase
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= pwmcap_pkg::PRE_1;
			clock_mhz_q <= 6'd8;
			enable_q    <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				pwmcap_pkg::REG_PRESCALE: prescale_q  <= pwdata[2:0];
				pwmcap_pkg::REG_CLOCK:    clock_mhz_q <= pwdata[5:0];
				pwmcap_pkg::REG_ENABLE:   enable_q    <= pwdata[0];
				default:                  enable_q    <= enable_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pwmcap_pkg::REG_PRESCALE: prdata = 32'(prescale_q);
			pwmcap_pkg::REG_CLOCK:    prdata = 32'(clock_mhz_q);
			pwmcap_pkg::REG_ENABLE:   prdata = 32'(enable_q);
			default:                  prdata = '0;
		endcase
	end

	// sequencing: tick handling, capture, divider schedule, result hand-off
	pwmcap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.operation (s_tuser),
		.sts       (sts),
		.cmd       (cmd)
	);

	// counter, phase registers, shared divider and output register
	pwmcap_dp #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.edge_rising     (s_tdata[0]),
		.prescale_select (prescale_q),
		.clock_mhz       (clock_mhz_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (result),
		.m_tuser         (m_tuser)
	);

	assign m_tdata = result;

endmodule

[src/pwmcap_dp.sv]
`timescale 1ns / 1ps

module pwmcap_dp #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pwmcap_pkg::cmd_t      cmd,
	output pwmcap_pkg::sts_t      sts,
	input  logic                  edge_rising,
	input  logic [2:0]            prescale_select,
	input  logic [5:0]            clock_mhz,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output pwmcap_pkg::result_t   m_tdata,
	output logic                  m_tuser
);

	localparam int TW = pwmcap_pkg::TICK_W;
	localparam int DW = pwmcap_pkg::DIV_W;

	logic [COUNTER_BITS-1:0] count_q;
	logic                    await_falling_q;
	logic [TW-1:0]           high_q;
	logic [TW-1:0]           low_q;
	logic                    cap_high_q;

	logic [DW-1:0] rem_q, quo_q, den_q;
	logic [DW-1:0] num_sel, den_sel;
	logic [DW:0]   trial;
	logic [DW:0]   trial_diff;
	logic [DW-1:0] quo_final;
	logic [TW-1:0] quo_sat;
	logic [TW:0]   total;

	logic [TW-1:0]                  period_q, freq_q, on_us_q, off_us_q;
	logic [pwmcap_pkg::DUTY_W-1:0] duty_q;

	logic                 out_valid_q;
	pwmcap_pkg::result_t out_q;
	logic                 out_high_q;

	// tick counter and phase capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			await_falling_q <= 1'b0;
			high_q          <= '0;
			low_q           <= '0;
		end else if (cmd.capture) begin
			if (await_falling_q)
				high_q <= TW'(count_q);
			else
				low_q <= TW'(count_q);
			count_q         <= '0;
			await_falling_q <= ~await_falling_q;
		end else if (cmd.tick) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			cap_high_q <= await_falling_q;
	end

	assign sts.edge_match = (edge_rising != await_falling_q);

	assign total = {1'b0, high_q} + {1'b0, low_q};

	// operands for the shared divider
	always_comb begin
		case (cmd.div_op)
			pwmcap_pkg::DIV_PERIOD: begin
				num_sel = pwmcap_pkg::prescale_apply(total, prescale_select);
				den_sel = DW'(clock_mhz);
			end
			pwmcap_pkg::DIV_ON_US: begin
				num_sel = pwmcap_pkg::prescale_apply({1'b0, high_q}, prescale_select);
				den_sel = DW'(clock_mhz);
			end
			pwmcap_pkg::DIV_OFF_US: begin
				num_sel = pwmcap_pkg::prescale_apply({1'b0, low_q}, prescale_select);
				den_sel = DW'(clock_mhz);
			end
			pwmcap_pkg::DIV_DUTY: begin
				num_sel = DW'(high_q) * pwmcap_pkg::PCT_SCALE;
				den_sel = DW'(total);
			end
			pwmcap_pkg::DIV_FREQ: begin
				num_sel = DW'(clock_mhz) * pwmcap_pkg::HZ_PER_MHZ;
				den_sel = pwmcap_pkg::prescale_apply(total, prescale_select);
			end
			default: begin
				num_sel = '0;
				den_sel = '0;
			end
		endcase
	end

	// restoring divider, one quotient bit per step
	assign trial      = {rem_q, quo_q[DW-1]};
	assign trial_diff = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= num_sel;
			den_q <= den_sel;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial_diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// zero divisor reads as zero, then clamp to 16 bits
	assign quo_final = (den_q == '0) ? '0 : quo_q;
	assign quo_sat   = (|quo_final[DW-1:TW]) ? pwmcap_pkg::SAT_MAX : quo_final[TW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (cmd.div_op)
				pwmcap_pkg::DIV_PERIOD: period_q <= quo_sat;
				pwmcap_pkg::DIV_ON_US:  on_us_q  <= quo_sat;
				pwmcap_pkg::DIV_OFF_US: off_us_q <= quo_sat;
				pwmcap_pkg::DIV_DUTY:   duty_q   <= quo_final[pwmcap_pkg::DUTY_W-1:0];
				pwmcap_pkg::DIV_FREQ:   freq_q   <= quo_sat;
				default:                period_q <= period_q;
			endcase
		end
	end

	// output register
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.pad          <= 1'b0;
			out_q.on_ticks     <= high_q;
			out_q.off_ticks    <= low_q;
			out_q.period_us    <= period_q;
			out_q.duty_percent <= duty_q;
			out_q.frequency_hz <= freq_q;
			out_q.on_time_us   <= on_us_q;
			out_q.off_time_us  <= off_us_q;
			out_high_q         <= cap_high_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_high_q;

endmodule

[src/pwmcap_ctrl.sv]
`timescale 1ns / 1ps

module pwmcap_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enable,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              operation,
	input  pwmcap_pkg::sts_t  sts,
	output pwmcap_pkg::cmd_t  cmd
);

	localparam int SW = pwmcap_pkg::STEP_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_STORE = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	pwmcap_pkg::div_op_t op_q, op_d;
	logic [SW-1:0]       step_q, step_d;
	logic                take;
	logic                last_step;

	assign s_tready  = (state_q == ST_IDLE);
	assign take      = s_tvalid && s_tready && enable;
	assign last_step = (step_q == SW'(pwmcap_pkg::DIV_W - 1));

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		step_d        = step_q;
		cmd           = '0;
		cmd.div_op    = op_q;
		case (state_q)
			ST_IDLE: begin
				if (take && operation == pwmcap_pkg::OP_TICK) begin
					cmd.tick = 1'b1;
				end else if (take && sts.edge_match) begin
					cmd.capture = 1'b1;
					op_d        = pwmcap_pkg::DIV_PERIOD;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				step_d       = '0;
				state_d      = ST_RUN;
			end
			ST_RUN: begin
				cmd.div_step = 1'b1;
				if (last_step)
					state_d = ST_STORE;
				else
					step_d = step_q + 1'b1;
			end
			ST_STORE: begin
				cmd.div_store = 1'b1;
				case (op_q)
					pwmcap_pkg::DIV_PERIOD: begin
						op_d = pwmcap_pkg::DIV_ON_US;  state_d = ST_LOAD;
					end
					pwmcap_pkg::DIV_ON_US: begin
						op_d = pwmcap_pkg::DIV_OFF_US; state_d = ST_LOAD;
					end
					pwmcap_pkg::DIV_OFF_US: begin
						op_d = pwmcap_pkg::DIV_DUTY;   state_d = ST_LOAD;
					end
					pwmcap_pkg::DIV_DUTY: begin
						op_d = pwmcap_pkg::DIV_FREQ;   state_d = ST_LOAD;
					end
					default: state_d = ST_FLUSH;
				endcase
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= pwmcap_pkg::DIV_PERIOD;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			step_q  <= step_d;
		end
	end

	// output register never overwritten while a result waits
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a waiting result");

	// no input handled while the divider is busy
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (!cmd.tick && !cmd.capture))
		else $error("input handled while busy");

	// a quotient is stored only right after the last step
	a_store_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_store |-> $past(cmd.div_step))
		else $error("quotient stored without a finished division");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= SW'(pwmcap_pkg::DIV_W - 1))
		else $error("divider step count out of range");

endmodule

[test/pwm_input_capture_measure_tb.sv]
`timescale 1ns / 1ps

// one expected measurement: the phase flag travels on tuser, the rest on tdata
typedef struct {
	logic                hi;
	pwmcap_pkg::result_t data;
} meas_t;

class pwm_meter;
	// register copies
	logic [2:0] pre_sel;
	logic [5:0] clk_mhz;
	logic       en;
	// capture state
	logic [15:0] count;
	logic        await_fall;
	logic [15:0] high_t;
	logic [15:0] low_t;
	meas_t       pending_reports[$];
	int          mismatches;

	function new();
		pre_sel = pwmcap_pkg::PRE_1;
		clk_mhz = 6'd8;
		en = 1'b0;
		count = '0;
		await_fall = 1'b0;
		high_t = '0;
		low_t = '0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			pwmcap_pkg::REG_PRESCALE: pre_sel = val[2:0];
			pwmcap_pkg::REG_CLOCK:    clk_mhz = val[5:0];
			pwmcap_pkg::REG_ENABLE:   en = val[0];
			default:      ;
		endcase
	endfunction

	function longint unsigned clocks_per_tick();
		case (pre_sel)
			pwmcap_pkg::PRE_1:    return 1;
			pwmcap_pkg::PRE_8:    return 8;
			pwmcap_pkg::PRE_64:   return 64;
			pwmcap_pkg::PRE_256:  return 256;
			pwmcap_pkg::PRE_1024: return 1024;
			default:  return 0;
		endcase
	endfunction

	function longint unsigned clip16(longint unsigned v);
		return (v > 65535) ? 65535 : v;
	endfunction

	function longint unsigned ticks_to_us(longint unsigned ticks, longint unsigned f);
		if (clk_mhz == 0)
			return 0;
		return clip16((ticks * f) / clk_mhz);
	endfunction

	// one accepted input transaction
	function void take_item(logic op, logic rising);
		meas_t           m;
		longint unsigned f;
		longint unsigned total;
		longint unsigned denom;
		if (!en)
			return;
		if (op == pwmcap_pkg::OP_TICK) begin
			count = count + 1'b1;
			return;
		end
		if (rising == await_fall)
			return;
		if (!await_fall)
			low_t = count;
		else
			high_t = count;
		count = '0;
		m.hi = await_fall;
		await_fall = !await_fall;
		f = clocks_per_tick();
		total = longint'(high_t) + longint'(low_t);
		denom = f * total;
		m.data = '0;
		m.data.on_ticks = high_t;
		m.data.off_ticks = low_t;
		m.data.period_us = 16'(ticks_to_us(total, f));
		m.data.duty_percent = (total == 0) ? '0 : 7'((longint'(high_t) * 100) / total);
		m.data.frequency_hz = (denom == 0) ? '0 :
			16'(clip16((longint'(clk_mhz) * 1000000) / denom));
		m.data.on_time_us = 16'(ticks_to_us(64'(high_t), f));
		m.data.off_time_us = 16'(ticks_to_us(64'(low_t), f));
		pending_reports.push_back(m);
	endfunction

	function void cmp(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endfunction

	// one accepted output transaction
	function void match_report(logic hi, logic [103:0] tdata);
		meas_t               m;
		pwmcap_pkg::result_t got;
		if (pending_reports.size() == 0) begin
			mismatches++;
			$display("%0t: measurement with none expected, captured_high %0d",
				$time, hi);
			return;
		end
		m = pending_reports.pop_front();
		got = tdata;
		cmp("captured_high", 64'(m.hi), 64'(hi));
		cmp("on_ticks", 64'(m.data.on_ticks), 64'(got.on_ticks));
		cmp("off_ticks", 64'(m.data.off_ticks), 64'(got.off_ticks));
		cmp("period_us", 64'(m.data.period_us), 64'(got.period_us));
		cmp("duty_percent", 64'(m.data.duty_percent), 64'(got.duty_percent));
		cmp("frequency_hz", 64'(m.data.frequency_hz), 64'(got.frequency_hz));
		cmp("on_time_us", 64'(m.data.on_time_us), 64'(got.on_time_us));
		cmp("off_time_us", 64'(m.data.off_time_us), 64'(got.off_time_us));
		cmp("pad", 64'(m.data.pad), 64'(got.pad));
	endfunction
endclass

module pwm_input_capture_measure_tb;

	localparam int CNT_BITS = 16;
	// a capturing edge keeps the block busy through five divisions and the hand-off, plus margin
	localparam int BUSY_CYCLES = 170;

	// invalid prescaler select codes
	localparam logic [2:0] PRE_NONE = 3'd0;
	localparam logic [2:0] PRE_RSVD6 = 3'd6;
	localparam logic [2:0] PRE_RSVD7 = 3'd7;

	localparam logic RISING = 1'b1;
	localparam logic FALLING = 1'b0;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;

	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;   // [0] edge_rising, [7:1] zero
	logic         s_tuser = 1'b0; // [0] operation

	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// [15:0] on_ticks, [31:16] off_ticks, [47:32] period_us, [54:48] duty_percent,
	// [70:55] frequency_hz, [86:71] on_time_us, [102:87] off_time_us, [103] zero
	logic [103:0] m_tdata;
	logic         m_tuser;        // [0] captured_high

	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// percentages of idle sender cycles and stalled receiver cycles
	int idle_pct = 0;
	int stall_pct = 0;

	pwm_meter book = new();

	pwm_input_capture_measure #(
		.COUNTER_BITS(CNT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: check every accepted transaction, then pick next cycle's tready
	// values read right after the edge are the ones the block saw at that edge
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			book.match_report(m_tuser, m_tdata);
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// one input transaction; returns at the edge that accepted it, optionally
	// followed by an idle gap so that gaps land on every phase of the block's work
	task automatic send_item(input logic op, input logic rising);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'b0, rising};
		do @(posedge clk); while (!s_tready);
		book.take_item(op, rising);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// ticks followed by an edge of the awaited polarity: one capture
	task automatic send_period(input int ticks);
		repeat (ticks) send_item(pwmcap_pkg::OP_TICK, 1'($urandom_range(1)));
		send_item(pwmcap_pkg::OP_EDGE, !book.await_fall);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [2:0] pre, input logic [5:0] mhz,
			input logic en);
		reg_write(pwmcap_pkg::REG_PRESCALE, {29'b0, pre});
		reg_write(pwmcap_pkg::REG_CLOCK, {26'b0, mhz});
		reg_write(pwmcap_pkg::REG_ENABLE, {31'b0, en});
	endtask

	// stop sending, wait for every expected measurement, then let the
	// divider finish anything that produced no measurement
	task automatic drain();
		s_tvalid <= 1'b0;
		while (book.pending_reports.size() != 0)
			@(posedge clk);
		repeat (BUSY_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed periods of random length, some wrong-polarity edges
	task automatic random_phase(input int n_items);
		int sent;
		int pick;
		int run;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 75)
				run = $urandom_range(0, 8);
			else if (pick < 95)
				run = $urandom_range(9, 80);
			else
				run = $urandom_range(81, 300);
			repeat (run) send_item(pwmcap_pkg::OP_TICK, 1'($urandom_range(1)));
			if ($urandom_range(99) < 15)
				send_item(pwmcap_pkg::OP_EDGE, book.await_fall);
			else
				send_item(pwmcap_pkg::OP_EDGE, !book.await_fall);
			sent += run + 1;
		end
	endtask

	initial begin
		int ph;
		int pre_pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: ticks and edges do nothing
		send_item(pwmcap_pkg::OP_TICK, FALLING);
		send_item(pwmcap_pkg::OP_EDGE, RISING);
		send_item(pwmcap_pkg::OP_EDGE, FALLING);
		drain();

		// first capture at zero count: zero total gives zero duty and frequency
		apply_setting(pwmcap_pkg::PRE_1, 6'd8, 1'b1);
		send_item(pwmcap_pkg::OP_EDGE, RISING);
		// wrong polarity, ignored
		send_item(pwmcap_pkg::OP_EDGE, RISING);
		send_period(2);
		drain();

		// no prescaler: all times and frequency read zero
		apply_setting(PRE_NONE, 6'd63, 1'b1);
		send_period(1);
		drain();

		// zero clock
		apply_setting(pwmcap_pkg::PRE_1, 6'd0, 1'b1);
		send_period(1);
		drain();

		// fastest setting: frequency saturates
		apply_setting(pwmcap_pkg::PRE_1, 6'd63, 1'b1);
		send_period(0);
		drain();

		// reserved prescaler codes
		apply_setting(PRE_RSVD7, 6'd1, 1'b1);
		send_period(1);
		drain();
		apply_setting(PRE_RSVD6, 6'd1, 1'b1);
		send_period(0);
		drain();

		// random part: four handshake pressure mixes, two settings each
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			case (ph)
				0: apply_setting(pwmcap_pkg::PRE_1, 6'd1, 1'b1);
				1: apply_setting(pwmcap_pkg::PRE_1024, 6'd63, 1'b1);
				2: apply_setting(pwmcap_pkg::PRE_1024, 6'd1, 1'b1);
				3: apply_setting(pwmcap_pkg::PRE_1, 6'd63, 1'b1);
				default: begin
					// mostly valid prescaler codes, sometimes a reserved one
					pre_pick = $urandom_range(99);
					if (pre_pick < 80)
						apply_setting(3'($urandom_range(pwmcap_pkg::PRE_1,
							pwmcap_pkg::PRE_1024)),
							6'($urandom_range(0, 63)), 1'b1);
					else
						apply_setting(3'($urandom_range(0, 7)),
							6'($urandom_range(0, 63)), 1'b1);
				end
			endcase
			random_phase(200);
			drain();
		end

		if (book.mismatches == 0 && book.pending_reports.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#15ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
